[rtl/bch_pkg.sv]
package bch_pkg;

   // Codeword layout
   localparam int WORD_W    = 32;
   localparam int SYN_W     = 10;
   localparam int DATA_LSB  = 11;
   localparam int NUM_DATA  = 21;
   localparam int NUM_CELLS = 31;
   localparam int NUM_PATS  = 31;

   // Generator aligned to the top of the word, and syndrome constants
   localparam logic [WORD_W-1:0] GEN_ALIGNED  = 32'hED20_0000;
   localparam logic [WORD_W-1:0] DATA_MASK    = 32'hFFFF_F800;
   localparam logic [SYN_W-1:0]  MSB_PATTERN  = 10'h3B4;
   // Feedback 0x769 with its top bit already cancelled by the shifted-out bit
   localparam logic [SYN_W-1:0]  SYN_FEEDBACK = 10'h369;

   // Syndromes that mark an error in the leading bit
   localparam logic [SYN_W-1:0] ERR_PATTERNS [NUM_PATS] = '{
      10'h3B4, 10'h26E, 10'h359, 10'h076, 10'h255, 10'h0F0, 10'h216, 10'h365,
      10'h068, 10'h25A, 10'h343, 10'h07B, 10'h1E7, 10'h129, 10'h14E, 10'h2C9,
      10'h0BE, 10'h231, 10'h0C2, 10'h20F, 10'h0DD, 10'h1B4, 10'h2B4, 10'h334,
      10'h3F4, 10'h394, 10'h3A4, 10'h3BC, 10'h3B0, 10'h3B6, 10'h3B5
   };

   // One beat moving down the cell chain
   typedef struct packed {
      logic              valid;
      logic [SYN_W-1:0]  syn;
      logic [WORD_W-1:0] word;
      logic [WORD_W-1:0] orig;
   } stage_type;

   // Check bits of a data pattern by long division (elaboration only)
   function automatic logic [SYN_W-1:0] div_check(input logic [WORD_W-1:0] data);
      logic [WORD_W-1:0] rem;
      rem = data & DATA_MASK;
      for (int k = 0; k < NUM_DATA; k++) begin
         if (rem[WORD_W-1]) rem = rem ^ GEN_ALIGNED;
         rem = rem << 1;
      end
      return rem[WORD_W-1 -: SYN_W];
   endfunction

   // Check-bit contribution of each data bit, packed 10 bits per column
   function automatic logic [NUM_DATA*SYN_W-1:0] build_syn_cols();
      logic [NUM_DATA*SYN_W-1:0] cols;
      cols = '0;
      for (int i = 0; i < NUM_DATA; i++) begin
         cols[i*SYN_W +: SYN_W] = div_check(WORD_W'(1) << (i + DATA_LSB));
      end
      return cols;
   endfunction

   localparam logic [NUM_DATA*SYN_W-1:0] SYN_COLS = build_syn_cols();

   // Leading-bit error pattern lookup
   function automatic logic is_msb_error(input logic [SYN_W-1:0] syn);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k < NUM_PATS; k++) begin
         if (syn == ERR_PATTERNS[k]) hit = 1'b1;
      end
      return hit;
   endfunction

endpackage

[rtl/bch_syn_calc.sv]
module bch_syn_calc
   import bch_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic [WORD_W-1:0] code_word,
   output stage_type         stage_out
);

   logic [SYN_W-1:0] syn_in;
   logic             valid_ff;
   logic [SYN_W-1:0] syn_ff;
   logic [WORD_W-1:0] word_ff;

   // Fold each set data bit's column into the received check bits
   always_comb begin
      syn_in = code_word[SYN_W:1];
      for (int i = 0; i < NUM_DATA; i++) begin
         if (code_word[i + DATA_LSB]) syn_in = syn_in ^ SYN_COLS[i*SYN_W +: SYN_W];
      end
   end

   // Track beat occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= load;
      end
   end

   // Capture syndrome and word
   always_ff @(posedge clock) begin
      syn_ff  <= syn_in;
      word_ff <= code_word;
   end

   assign stage_out.valid = valid_ff;
   assign stage_out.syn   = syn_ff;
   assign stage_out.word  = word_ff;
   assign stage_out.orig  = word_ff;

endmodule

[rtl/bch_meggitt_cell.sv]
module bch_meggitt_cell
   import bch_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  stage_type stage_in,
   output stage_type stage_out
);

   logic              hit;
   logic [SYN_W-1:0]  syn_fix;
   stage_type         stage_in_c;
   logic              valid_ff;
   logic [SYN_W-1:0]  syn_ff;
   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] orig_ff;

   // Correct the leading bit, then clock the syndrome once
   always_comb begin
      hit     = is_msb_error(stage_in.syn);
      syn_fix = hit ? (stage_in.syn ^ MSB_PATTERN) : stage_in.syn;
      stage_in_c       = stage_in;
      stage_in_c.syn   = syn_fix[SYN_W-1] ? ({syn_fix[SYN_W-2:0], 1'b0} ^ SYN_FEEDBACK)
                                          : {syn_fix[SYN_W-2:0], 1'b0};
      // Rotate the word left so the next bit under test reaches the top
      stage_in_c.word  = {stage_in.word[WORD_W-2:0], stage_in.word[WORD_W-1] ^ hit};
   end

   // Track beat occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage_in.valid;
      end
   end

   // Advance payload to the neighbor
   always_ff @(posedge clock) begin
      syn_ff  <= stage_in_c.syn;
      word_ff <= stage_in_c.word;
      orig_ff <= stage_in.orig;
   end

   assign stage_out.valid = valid_ff;
   assign stage_out.syn   = syn_ff;
   assign stage_out.word  = word_ff;
   assign stage_out.orig  = orig_ff;

endmodule

[rtl/bch_31_21_error_corrector.sv]
// Channel   Ports                                          Handshake
// -------   ---------------------------------------------  --------------------------
// request   req_code_word                                  start high, busy low
// response  rsp_corrected_word, rsp_decode_ok              rsp_strobe, one cycle
//
// A word is taken every cycle; busy never rises. Each result passes through the
// chain in order: the syndrome register forms the syndrome, 31 Meggitt cells each
// test and shift one bit, and the output register picks the corrected or the
// received word. Reset clears only the valid bits of the chain. The receiver
// cannot stall, so every result is shown for exactly one cycle.
module bch_31_21_error_corrector
   import bch_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [WORD_W-1:0] req_code_word,
   output logic              rsp_strobe,
   output logic [WORD_W-1:0] rsp_corrected_word,
   output logic              rsp_decode_ok
);

   stage_type         chain [NUM_CELLS+1];
   stage_type         last;
   logic              ok_in;
   logic [WORD_W-1:0] word_in;
   logic              strobe_ff;
   logic [WORD_W-1:0] word_ff;
   logic              ok_ff;

   assign busy = 1'b0;

   bch_syn_calc u_syn (
      .clock     (clock),
      .reset     (reset),
      .load      (start),
      .code_word (req_code_word),
      .stage_out (chain[0])
   );

   // Chain of correction cells
   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      bch_meggitt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (chain[g]),
         .stage_out (chain[g+1])
      );
   end

   // Undo the final rotation and pick the result
   always_comb begin
      last    = chain[NUM_CELLS];
      ok_in   = (last.syn == '0);
      word_in = ok_in ? {last.word[WORD_W-2:0], last.word[WORD_W-1]} : last.orig;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= last.valid;
      end
   end

   // Hold the result beat
   always_ff @(posedge clock) begin
      word_ff <= word_in;
      ok_ff   <= ok_in;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_corrected_word = word_ff;
   assign rsp_decode_ok      = ok_ff;

endmodule
